// ===== hw/rtl/bia_pkg.sv =====
// ----------------------------------------------------------------------------
// bia_pkg
// Shared types, sizes and helper functions for the bitmap identifier
// allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

	// Identifier and bitmap geometry.
	localparam int ID_W      = 16;
	localparam int WORD_W    = 32;
	localparam int BIT_W     = 5;
	localparam int IDX_W     = ID_W - BIT_W;
	localparam int MAP_WORDS = 2048;
	localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CNT_W     = $clog2(MAP_WORDS + 2);

	// Number of word reads after which an allocation gives up.
	localparam logic [CNT_W-1:0] SCAN_LIMIT = CNT_W'(MAP_WORDS + 1);

	// Operation codes of a request.
	typedef enum logic [2:0] {
		OP_ALLOC   = 3'd0,
		OP_MARK    = 3'd1,
		OP_RELEASE = 3'd2,
		OP_TEST    = 3'd3,
		OP_CLEAR   = 3'd4
	} op_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_WIPE
	} state_t;

	// Result of a search for the lowest set bit of a word.
	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] pos;
	} find_t;

	// True when a word index lies inside the stored map.
	function automatic logic idx_in_map(input logic [IDX_W-1:0] idx);
		return ({1'b0, idx} < (IDX_W + 1)'(MAP_WORDS));
	endfunction

	// Lowest set bit: isolate it, then encode each position bit independently.
	function automatic find_t find_lowest(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] low;
		find_t             r;
		low     = v & (~v + WORD_W'(1));
		r.found = |v;
		for (int k = 0; k < BIT_W; k++) begin
			r.pos[k] = 1'b0;
			for (int i = 0; i < WORD_W; i++) begin
				if (((i >> k) & 1) == 1) begin
					r.pos[k] = r.pos[k] | low[i];
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/bia_req_if.sv =====
// ----------------------------------------------------------------------------
// bia_req_if
// Request channel of the allocator: operation code and identifier.
// ----------------------------------------------------------------------------
interface bia_req_if;
	import bia_pkg::*;

	logic            valid;
	logic            ready;
	logic [2:0]      op;
	logic [ID_W-1:0] ident;

	modport source (output valid, output op, output ident, input ready);
	modport sink   (input valid, input op, input ident, output ready);
endinterface

// ===== hw/rtl/bia_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bia_rsp_if
// Response channel of the allocator: identifier, previous bit and full flag.
// ----------------------------------------------------------------------------
interface bia_rsp_if;
	import bia_pkg::*;

	logic            valid;
	logic            ready;
	logic [ID_W-1:0] ident_out;
	logic            was_used;
	logic            full_res;

	modport source (output valid, output ident_out, output was_used, output full_res,
		input ready);
	modport sink   (input valid, input ident_out, input was_used, input full_res,
		output ready);
endinterface

// ===== hw/rtl/bitmap_id_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_id_allocator_core
// Next-fit identifier allocator over a bitmap held in one synchronous RAM.
// ----------------------------------------------------------------------------
//  Channel | Role | Contents
//  --------+------+------------------------------------------------
//  req     | in   | op (3 bits), ident (16 bits)
//  rsp     | out  | ident_out (16 bits), was_used, full_res
//
// Mark, release and test read the word on acceptance, then evaluate it, write it
// back and register the response; the unused codes only register a response.
// Allocate reads one bitmap word at a time from just after the dealer, at most
// MAP_WORDS + 1 words when the map is full; the single RAM read port sets this.
// Clear sweeps the RAM one word per cycle, then registers its response.
// After reset a clearing pass over all MAP_WORDS words runs before any request.
// A waiting response stalls the next request only in its response step.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_core (
	input  logic      clk,
	input  logic      arst_n,
	bia_req_if.sink   req,
	bia_rsp_if.source rsp
);
	import bia_pkg::*;

	// Bitmap storage and its read register.
	logic [WORD_W-1:0]  mem [MAP_WORDS];
	logic [WORD_W-1:0]  rdata_q;
	logic               rd_en;
	logic [WADDR_W-1:0] rd_addr;
	logic               wr_en;
	logic [WADDR_W-1:0] wr_addr;
	logic [WORD_W-1:0]  wr_data;

	// Controller state and the request being worked on.
	state_t             state_q, state_n;
	logic [2:0]         op_q, op_n;
	logic [ID_W-1:0]    ident_q, ident_n;
	logic               inmap_q, inmap_n;
	logic [WADDR_W-1:0] word_q, word_n;
	logic [BIT_W-1:0]   low_q, low_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic [ID_W-1:0]    dealer_q, dealer_n;
	logic [WADDR_W-1:0] sweep_q, sweep_n;

	// Response register.
	logic               rsp_valid_q, rsp_valid_n;
	logic [ID_W-1:0]    ident_out_q, ident_out_n;
	logic               was_q, was_n;
	logic               full_q, full_n;

	// Helper signals.
	logic               accept;
	logic               rsp_free;
	logic [ID_W-1:0]    cand;
	logic [IDX_W-1:0]   cand_idx;
	logic [IDX_W-1:0]   req_idx;
	logic               req_inmap;
	logic               cur_bit;
	logic [WORD_W-1:0]  bit_mask;
	logic [WORD_W-1:0]  free_bits;
	find_t              hit;
	logic [WADDR_W:0]   next_word;

	assign req.ready     = (state_q == ST_IDLE);
	assign accept        = req.valid && req.ready;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.ident_out = ident_out_q;
	assign rsp.was_used  = was_q;
	assign rsp.full_res  = full_q;

	// Word decoding for the incoming request and the word under evaluation.
	always_comb begin
		cand      = dealer_q + ID_W'(1);
		cand_idx  = cand[ID_W-1:BIT_W];
		req_idx   = req.ident[ID_W-1:BIT_W];
		req_inmap = idx_in_map(req_idx);
		bit_mask  = WORD_W'(1) << ident_q[BIT_W-1:0];
		cur_bit   = inmap_q && rdata_q[ident_q[BIT_W-1:0]];
		free_bits = ~rdata_q & ({WORD_W{1'b1}} << low_q);
		hit       = find_lowest(free_bits);
		next_word = {1'b0, word_q} + (WADDR_W + 1)'(1);
		rsp_free  = !rsp_valid_q || rsp.ready;
	end

	// Next state, RAM accesses and the response.
	always_comb begin
		state_n     = state_q;
		op_n        = op_q;
		ident_n     = ident_q;
		inmap_n     = inmap_q;
		word_n      = word_q;
		low_n       = low_q;
		cnt_n       = cnt_q;
		dealer_n    = dealer_q;
		sweep_n     = sweep_q;
		rsp_valid_n = rsp_valid_q && !rsp.ready;
		ident_out_n = ident_out_q;
		was_n       = was_q;
		full_n      = full_q;
		rd_en       = 1'b0;
		rd_addr     = word_q;
		wr_en       = 1'b0;
		wr_addr     = word_q;
		wr_data     = rdata_q;

		case (state_q)
			ST_INIT, ST_WIPE: begin
				// Clearing sweep: every word zero except the reserved bit of word 0.
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = (sweep_q == '0) ? WORD_W'(1) : '0;
				sweep_n = sweep_q + WADDR_W'(1);
				if (sweep_q == WADDR_W'(MAP_WORDS - 1)) begin
					sweep_n = '0;
					state_n = (state_q == ST_INIT) ? ST_IDLE : ST_EXEC;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					op_n    = req.op;
					ident_n = req.ident;
					inmap_n = req_inmap;
					word_n  = req_idx[WADDR_W-1:0];
					low_n   = '0;
					cnt_n   = CNT_W'(1);
					state_n = ST_EXEC;
					case (req.op)
						OP_ALLOC: begin
							// Scan starts just after the dealer, or at word 0 if that is
							// beyond the map.
							if (idx_in_map(cand_idx)) begin
								word_n = cand_idx[WADDR_W-1:0];
								low_n  = cand[BIT_W-1:0];
							end else begin
								word_n = '0;
							end
							rd_en   = 1'b1;
							rd_addr = word_n;
						end
						OP_MARK, OP_RELEASE, OP_TEST: begin
							rd_en   = req_inmap;
							rd_addr = req_idx[WADDR_W-1:0];
						end
						OP_CLEAR: begin
							sweep_n = '0;
							state_n = ST_WIPE;
						end
						default: begin
						end
					endcase
				end
			end
			ST_EXEC: begin
				case (op_q)
					OP_ALLOC: begin
						if (hit.found) begin
							// Free identifier found: claim it and move the dealer.
							if (rsp_free) begin
								wr_en       = 1'b1;
								wr_data     = rdata_q | (WORD_W'(1) << hit.pos);
								dealer_n    = {IDX_W'(word_q), hit.pos};
								rsp_valid_n = 1'b1;
								ident_out_n = {IDX_W'(word_q), hit.pos};
								was_n       = 1'b0;
								full_n      = 1'b0;
								state_n     = ST_IDLE;
							end
						end else if (cnt_q == SCAN_LIMIT) begin
							// Every word has been seen, the start word twice.
							if (rsp_free) begin
								rsp_valid_n = 1'b1;
								ident_out_n = '0;
								was_n       = 1'b1;
								full_n      = 1'b1;
								state_n     = ST_IDLE;
							end
						end else begin
							// Move on to the next word, wrapping at the end of the map.
							word_n  = (next_word == (WADDR_W + 1)'(MAP_WORDS)) ?
								'0 : next_word[WADDR_W-1:0];
							low_n   = '0;
							cnt_n   = cnt_q + CNT_W'(1);
							rd_en   = 1'b1;
							rd_addr = word_n;
						end
					end
					OP_MARK, OP_RELEASE, OP_TEST: begin
						if (rsp_free) begin
							wr_en       = inmap_q && ((op_q == OP_MARK) ||
								((op_q == OP_RELEASE) && (ident_q != '0)));
							wr_data     = (op_q == OP_MARK) ? (rdata_q | bit_mask) :
								(rdata_q & ~bit_mask);
							rsp_valid_n = 1'b1;
							ident_out_n = ident_q;
							was_n       = cur_bit;
							full_n      = 1'b0;
							state_n     = ST_IDLE;
						end
					end
					default: begin
						// Clear after its sweep, and the unused codes.
						if (rsp_free) begin
							rsp_valid_n = 1'b1;
							ident_out_n = '0;
							was_n       = 1'b0;
							full_n      = 1'b0;
							state_n     = ST_IDLE;
						end
					end
				endcase
			end
			default: begin
				state_n = ST_INIT;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			dealer_q    <= '0;
			sweep_q     <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			dealer_q    <= dealer_n;
			sweep_q     <= sweep_n;
			cnt_q       <= cnt_n;
			rsp_valid_q <= rsp_valid_n;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		op_q        <= op_n;
		ident_q     <= ident_n;
		inmap_q     <= inmap_n;
		word_q      <= word_n;
		low_q       <= low_n;
		ident_out_q <= ident_out_n;
		was_q       <= was_n;
		full_q      <= full_n;
	end

	// Bitmap RAM: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/bia_checker.sv =====
// ----------------------------------------------------------------------------
// bia_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bia_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic [bia_pkg::ID_W-1:0] ident_out,
	input logic                  was_used,
	input logic                  full_res
);
	import bia_pkg::*;

	logic [1:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Count of requests accepted whose response has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_acc) - 2'(rsp_acc);
		end
	end

	// A full response carries identifier zero and was_used set.
	a_full_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && full_res) |-> (ident_out == '0) && was_used)
		else $error("full response with wrong payload");

	// A stalled response holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid && $stable(ident_out) &&
		$stable(was_used) && $stable(full_res))
		else $error("stalled response changed");

	// No response without an accepted request.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pend_q != 2'd0))
		else $error("response without request");

	// At most one request at work and one response waiting.
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many requests outstanding");

endmodule

bind bitmap_id_allocator_core bia_checker u_bia_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.ident_out (rsp.ident_out),
	.was_used  (rsp.was_used),
	.full_res  (rsp.full_res)
);

// ===== tb/tb_bitmap_id_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_id_allocator_core
// Self-checking testbench for the bitmap identifier allocator. A table of
// directed requests is followed by a short back-to-back run of allocations and
// releases, then by weighted random requests. Every response is checked, field by
// field, against its pinned table row or a shadow bitmap and dealer in the bench.
// ----------------------------------------------------------------------------
module tb_bitmap_id_allocator_core;
	import bia_pkg::*;

	// Operation codes the block treats as no-ops.
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	localparam int N_DIRECTED  = 25;
	localparam int N_RANDOM    = 1100;
	localparam int MAX_GAP     = 12;
	localparam int POOL_DEPTH  = 48;
	localparam int DRAIN_WAIT  = MAP_WORDS + 16;

	typedef struct packed {
		logic [ID_W-1:0] ident;
		logic            was_used;
		logic            full_res;
	} reply_t;

	// One row of directed stimulus; pinned rows carry their expected response.
	typedef struct packed {
		logic [2:0]      op;
		logic [ID_W-1:0] ident;
		logic            pinned;
		reply_t          reply;
	} dir_row_t;

	logic clk;
	logic arst_n;

	bia_req_if req_ch ();
	bia_rsp_if rsp_ch ();

	bitmap_id_allocator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the allocator state.
	logic [WORD_W-1:0] shadow_map [MAP_WORDS];
	logic [ID_W-1:0]   shadow_dealer;

	reply_t          pending_replies [$];
	logic [ID_W-1:0] live_ids [$];
	int              err_count = 0;
	logic            idle_on;

	dir_row_t dir_tbl [N_DIRECTED] = '{
		'{OP_TEST,    16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0}},
		'{OP_TEST,    16'hFFFF, 1'b1, '{16'hFFFF, 1'b0, 1'b0}},
		'{OP_ALLOC,   16'h0000, 1'b1, '{16'h0001, 1'b0, 1'b0}},
		'{OP_ALLOC,   16'hFFFF, 1'b1, '{16'h0002, 1'b0, 1'b0}},
		'{OP_MARK,    16'h0003, 1'b1, '{16'h0003, 1'b0, 1'b0}},
		'{OP_ALLOC,   16'h0000, 1'b1, '{16'h0004, 1'b0, 1'b0}},
		'{OP_MARK,    16'hFFFF, 1'b1, '{16'hFFFF, 1'b0, 1'b0}},
		'{OP_MARK,    16'hFFFF, 1'b1, '{16'hFFFF, 1'b1, 1'b0}},
		'{OP_RELEASE, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0}},
		'{OP_TEST,    16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0}},
		'{OP_RELEASE, 16'h0003, 1'b1, '{16'h0003, 1'b1, 1'b0}},
		'{OP_RELEASE, 16'h0003, 1'b1, '{16'h0003, 1'b0, 1'b0}},
		'{OP_MARK,    16'hAAAA, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{OP_MARK,    16'h5555, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{OP_TEST,    16'hAAAA, 1'b1, '{16'hAAAA, 1'b1, 1'b0}},
		'{OP_MARK,    16'h001F, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{OP_MARK,    16'h0020, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{OP_RELEASE, 16'hFFFF, 1'b1, '{16'hFFFF, 1'b1, 1'b0}},
		'{OP_SPARE_5, 16'h1234, 1'b1, '{16'h0000, 1'b0, 1'b0}},
		'{OP_SPARE_6, 16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b0}},
		'{OP_SPARE_7, 16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0}},
		'{OP_CLEAR,   16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0}},
		'{OP_TEST,    16'h0001, 1'b1, '{16'h0001, 1'b0, 1'b0}},
		'{OP_ALLOC,   16'h0000, 1'b1, '{16'h0005, 1'b0, 1'b0}},
		'{OP_ALLOC,   16'h0000, 1'b0, '{16'h0000, 1'b0, 1'b0}}
	};

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run, far above the slowest correct run.
	initial begin
		#100ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic id_in_map(input logic [ID_W-1:0] id);
		return (int'(id >> BIT_W) < MAP_WORDS);
	endfunction

	function automatic logic id_bit(input logic [ID_W-1:0] id);
		if (!id_in_map(id)) begin
			return 1'b0;
		end
		return shadow_map[id[ID_W-1:BIT_W]][id[BIT_W-1:0]];
	endfunction

	function automatic void set_bit(input logic [ID_W-1:0] id, input logic v);
		if (id_in_map(id)) begin
			shadow_map[id[ID_W-1:BIT_W]][id[BIT_W-1:0]] = v;
		end
	endfunction

	function automatic void wipe_shadow();
		for (int w = 0; w < MAP_WORDS; w++) begin
			shadow_map[w] = '0;
		end
		shadow_map[0][0] = 1'b1;
	endfunction

	// Applies one request to the shadow state and returns the response it causes.
	function automatic reply_t predict_reply(input logic [2:0] op, input logic [ID_W-1:0] id);
		reply_t          r;
		logic [ID_W-1:0] cand;
		logic            found;
		r     = '0;
		cand  = shadow_dealer;
		found = 1'b0;
		case (op)
			OP_ALLOC: begin
				// Next-fit walk from the dealer, wrapping through the whole space.
				for (int n = 0; n < (1 << ID_W) && !found; n++) begin
					cand = cand + 1'b1;
					if (id_in_map(cand) && !id_bit(cand)) begin
						found = 1'b1;
					end
				end
				if (found) begin
					shadow_dealer = cand;
					set_bit(cand, 1'b1);
					r.ident = cand;
				end else begin
					r.was_used = 1'b1;
					r.full_res = 1'b1;
				end
			end
			OP_MARK: begin
				r.ident    = id;
				r.was_used = id_bit(id);
				set_bit(id, 1'b1);
			end
			OP_RELEASE: begin
				r.ident    = id;
				r.was_used = id_bit(id);
				if (id != '0) begin
					set_bit(id, 1'b0);
				end
			end
			OP_TEST: begin
				r.ident    = id;
				r.was_used = id_bit(id);
			end
			OP_CLEAR: begin
				wipe_shadow();
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Presents one request, after a random gap while idling is on, and logs its
	// expected response once it is accepted.
	task automatic send_request(input logic [2:0] op, input logic [ID_W-1:0] id,
		input logic pinned, input reply_t pinned_reply, output reply_t model);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.ident <= id;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		model = predict_reply(op, id);
		pending_replies.push_back(pinned ? pinned_reply : model);
	endtask

	task automatic send_checked(input logic [2:0] op, input logic [ID_W-1:0] id,
		output reply_t model);
		send_request(op, id, 1'b0, '0, model);
	endtask

	// Picks an identifier: many ones in play, some extremes, the rest uniform.
	function automatic logic [ID_W-1:0] pick_ident();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 45 && live_ids.size() != 0) begin
			return live_ids[$urandom_range(0, live_ids.size() - 1)];
		end else if (sel < 60) begin
			case ($urandom_range(0, 7))
				0: return 16'h0000;
				1: return 16'h0001;
				2: return 16'h001F;
				3: return 16'h0020;
				4: return 16'h7FFF;
				5: return 16'h8000;
				6: return 16'hFFFE;
				default: return 16'hFFFF;
			endcase
		end
		return ID_W'($urandom);
	endfunction

	function automatic void remember_id(input logic [ID_W-1:0] id);
		live_ids.push_back(id);
		if (live_ids.size() > POOL_DEPTH) begin
			void'(live_ids.pop_front());
		end
	endfunction

	// Response side: random back-pressure while idling is on, and comparison with
	// the oldest expected response.
	initial begin : reply_sink
		int     stall;
		reply_t want;
		reply_t got;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (rsp_ch.valid !== 1'b1) @(posedge clk);
			got = '{rsp_ch.ident_out, rsp_ch.was_used, rsp_ch.full_res};
			if (pending_replies.size() == 0) begin
				$display("%0t: response with none expected: ident_out %h was_used %b full_res %b",
					$time, got.ident, got.was_used, got.full_res);
				err_count++;
			end else begin
				want = pending_replies.pop_front();
				if (got.ident !== want.ident) begin
					$display("%0t: ident_out expected %h actual %h", $time, want.ident, got.ident);
					err_count++;
				end
				if (got.was_used !== want.was_used) begin
					$display("%0t: was_used expected %b actual %b", $time, want.was_used,
						got.was_used);
					err_count++;
				end
				if (got.full_res !== want.full_res) begin
					$display("%0t: full_res expected %b actual %b", $time, want.full_res,
						got.full_res);
					err_count++;
				end
			end
		end
	end

	// Request side: directed table, a back-to-back probe, then random requests.
	initial begin : request_source
		reply_t          model;
		logic [2:0]      op;
		logic [ID_W-1:0] id;
		int              sel;
		idle_on       = 1'b1;
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.op     = OP_TEST;
		req_ch.ident  = '0;
		shadow_dealer = '0;
		wipe_shadow();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests from the table.
		foreach (dir_tbl[i]) begin
			send_request(dir_tbl[i].op, dir_tbl[i].ident, dir_tbl[i].pinned,
				dir_tbl[i].reply, model);
		end

		// Back-to-back allocations and releases, so that next-fit dealing has
		// to step past freed identifiers behind the dealer.
		idle_on = 1'b0;
		send_checked(OP_ALLOC, 16'h0000, model);
		send_checked(OP_RELEASE, 16'h0002, model);
		send_checked(OP_ALLOC, 16'hFFFF, model);
		send_checked(OP_RELEASE, 16'hFFFF, model);
		send_checked(OP_ALLOC, 16'h0000, model);
		send_checked(OP_RELEASE, 16'h0001, model);
		send_checked(OP_ALLOC, 16'h0000, model);
		send_checked(OP_ALLOC, 16'h0000, model);
		send_checked(OP_CLEAR, 16'hFFFF, model);

		// Weighted random requests, idling switched on and off in stretches.
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 50 == 0) begin
				idle_on = ($urandom_range(0, 3) != 0);
			end
			sel = $urandom_range(0, 99);
			id  = pick_ident();
			if (sel < 35) begin
				op = OP_ALLOC;
			end else if (sel < 52) begin
				op = OP_MARK;
			end else if (sel < 75) begin
				op = OP_RELEASE;
			end else if (sel < 95) begin
				op = OP_TEST;
			end else if (sel < 97) begin
				op = OP_CLEAR;
			end else begin
				op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
			end
			send_checked(op, id, model);
			if (op == OP_ALLOC && !model.full_res) begin
				remember_id(model.ident);
			end else if (op == OP_MARK) begin
				remember_id(id);
			end
		end

		// Drain outstanding responses, then watch for stray ones.
		req_ch.valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/bia_pkg.sv
hw/rtl/bia_req_if.sv
hw/rtl/bia_rsp_if.sv
hw/rtl/bitmap_id_allocator_core.sv
hw/rtl/bia_checker.sv
tb/tb_bitmap_id_allocator_core.sv
